// File: design/rfd_pkg.sv
package rfd_pkg;

    localparam logic [7:0]  HEAD_BYTE     = 8'hAA;
    localparam logic [15:0] CRC_POLY      = 16'h8005;
    localparam int unsigned ADDR_FLAG_BIT = 5;
    localparam int unsigned INIT_FLAG_BIT = 4;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;
    localparam logic [15:0] READER_ERR_LEN = 16'd6;

    // config register map (byte address = 4 * index)
    localparam int unsigned CFG_ADDR_W    = 3;
    localparam logic        REG_MAX_LEN   = 1'b0;

    // result queue
    localparam int unsigned OUTQ_DEPTH    = 2;
    localparam int unsigned OUTQ_PTR_W    = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUTQ_CNT_W    = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_CTRL = 4'd1,
        PH_ID   = 4'd2,
        PH_ADDR = 4'd3,
        PH_LENH = 4'd4,
        PH_LENL = 4'd5,
        PH_DATA = 4'd6,
        PH_CRCH = 4'd7,
        PH_CRCL = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_CRC_ERR = 2'd2,
        KIND_TOO_LONG = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_value;
        logic [15:0] payload_index;
        logic [7:0]  control_word;
        logic [7:0]  message_id;
        logic [7:0]  device_address;
        logic [15:0] payload_length;
        logic [15:0] crc_computed;
        logic        reader_error;
        logic        frame_end;
    } t_result;

    // one byte through the MSB-first CRC, no reflection
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        logic [7:0]  b;
        logic        fb;
        crc = crc_in;
        b   = data;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[15] ^ b[7];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            b   = {b[6:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

// File: design/rfd_cfg.sv
module rfd_cfg
    import rfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [15:0]           o_max_len
);

    logic [15:0] r_max_len;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_MAX_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (wr_en) begin
            r_max_len <= pwdata[15:0];
        end
    end

    assign prdata    = (paddr[2] == REG_MAX_LEN) ? {16'h0000, r_max_len} : 32'h0;
    assign pready    = 1'b1;
    assign o_max_len = r_max_len;

endmodule

// File: design/rfd_parse.sv
module rfd_parse
    import rfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_max_len,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase,   n_phase;
    logic [15:0] r_crc,     n_crc;
    logic [15:0] r_count,   n_count;
    logic [7:0]  r_control, n_control;
    logic [7:0]  r_msg_id,  n_msg_id;
    logic [7:0]  r_address, n_address;
    logic [15:0] r_length,  n_length;
    logic [7:0]  r_crc_hi,  n_crc_hi;
    logic [15:0] crc_upd;

    assign crc_upd = crc16_byte(r_crc, i_rx_byte);

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_crc     = r_crc;
        n_count   = r_count;
        n_control = r_control;
        n_msg_id  = r_msg_id;
        n_address = r_address;
        n_length  = r_length;
        n_crc_hi  = r_crc_hi;
        case (r_phase)
            PH_CTRL: begin
                n_crc     = crc_upd;
                n_control = i_rx_byte;
                n_phase   = PH_ID;
            end
            PH_ID: begin
                n_crc    = crc_upd;
                n_msg_id = i_rx_byte;
                n_phase  = r_control[ADDR_FLAG_BIT] ? PH_ADDR : PH_LENH;
            end
            PH_ADDR: begin
                n_crc     = crc_upd;
                n_address = i_rx_byte;
                n_phase   = PH_LENH;
            end
            PH_LENH: begin
                n_crc    = crc_upd;
                n_length = {i_rx_byte, 8'h00};
                n_phase  = PH_LENL;
            end
            PH_LENL: begin
                n_crc    = crc_upd;
                n_length = {r_length[15:8], i_rx_byte};
                n_count  = 16'h0000;
                if (n_length > i_max_len) begin
                    n_phase = PH_HUNT;
                end else if (n_length == 16'h0000) begin
                    n_phase = PH_CRCH;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_crc   = crc_upd;
                n_count = r_count + 16'd1;
                if (n_count >= r_length) begin
                    n_phase = PH_CRCH;
                end
            end
            PH_CRCH: begin
                n_crc_hi = i_rx_byte;
                n_phase  = PH_CRCL;
            end
            PH_CRCL: begin
                n_phase = PH_HUNT;
            end
            default: begin
                // hunt; stray phase codes land here too
                if (i_rx_byte == HEAD_BYTE) begin
                    n_crc     = 16'h0000;
                    n_count   = 16'h0000;
                    n_address = 8'h00;
                    n_phase   = PH_CTRL;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    // result for this byte, built from the updated frame fields
    always_comb begin
        o_res_valid          = 1'b0;
        o_res.kind           = KIND_DATA;
        o_res.byte_value     = 8'h00;
        o_res.payload_index  = 16'h0000;
        o_res.control_word   = n_control;
        o_res.message_id     = n_msg_id;
        o_res.device_address = n_address;
        o_res.payload_length = n_length;
        o_res.crc_computed   = n_crc;
        o_res.frame_end      = 1'b1;
        case (r_phase)
            PH_LENL: begin
                o_res_valid = (n_length > i_max_len);
                o_res.kind  = KIND_TOO_LONG;
            end
            PH_DATA: begin
                o_res_valid         = 1'b1;
                o_res.kind          = KIND_DATA;
                o_res.byte_value    = i_rx_byte;
                o_res.payload_index = r_count;
                o_res.frame_end     = 1'b0;
            end
            PH_CRCL: begin
                o_res_valid = 1'b1;
                o_res.kind  = ({r_crc_hi, i_rx_byte} == r_crc) ? KIND_GOOD : KIND_CRC_ERR;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
        o_res.reader_error = o_res.frame_end && n_control[INIT_FLAG_BIT] &&
                             (n_msg_id == 8'h00) && (n_length == READER_ERR_LEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_crc     <= 16'h0000;
            r_count   <= 16'h0000;
            r_control <= 8'h00;
            r_msg_id  <= 8'h00;
            r_address <= 8'h00;
            r_length  <= 16'h0000;
            r_crc_hi  <= 8'h00;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_crc     <= n_crc;
            r_count   <= n_count;
            r_control <= n_control;
            r_msg_id  <= n_msg_id;
            r_address <= n_address;
            r_length  <= n_length;
            r_crc_hi  <= n_crc_hi;
        end
    end

endmodule

// File: design/rfd_outq.sv
module rfd_outq
    import rfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    t_result               r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wptr;
    logic [OUTQ_PTR_W-1:0] r_rptr;
    logic [OUTQ_CNT_W-1:0] r_count;
    logic                  do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == OUTQ_CNT_W'(OUTQ_DEPTH));
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/reader_frame_deframer_crc16.sv
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+---------------------------------------------
// rx in     | i_in_valid / o_in_ready       | i_rx_byte
// result    | o_out_valid / i_out_ready     | o_kind .. o_frame_end (ten fields)
// config    | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata (max_payload_len @ 0)
//
// One byte is taken per cycle while the queue has a free slot. The parser
// updates phase, CRC and frame fields in the cycle the byte is accepted; any
// result is written into a two-entry queue and offered from its head.
// o_in_ready drops only when both queue entries are occupied.
// Synchronous active-low reset: parser hunts for the head byte, queue empty,
// max_payload_len back to 1024.
module reader_frame_deframer_crc16
    import rfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // received byte stream
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_rx_byte,

    // results
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_byte_value,
    output logic [15:0]           o_payload_index,
    output logic [7:0]            o_control_word,
    output logic [7:0]            o_message_id,
    output logic [7:0]            o_device_address,
    output logic [15:0]           o_payload_length,
    output logic [15:0]           o_crc_computed,
    output logic                  o_reader_error,
    output logic                  o_frame_end,

    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic        max_len_lim;
    logic [15:0] max_len;
    logic        take;
    logic        res_valid;
    t_result     res;
    logic        q_full;
    t_result     q_data;

    assign max_len_lim = 1'b1;

    rfd_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (max_len)
    );

    // byte accepted whenever the queue has a free slot
    assign o_in_ready = !q_full;
    assign take       = i_in_valid && o_in_ready && max_len_lim;

    rfd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx_byte),
        .i_max_len   (max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rfd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take && res_valid),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_pop   (i_out_ready),
        .o_data  (q_data)
    );

    assign o_kind           = q_data.kind;
    assign o_byte_value     = q_data.byte_value;
    assign o_payload_index  = q_data.payload_index;
    assign o_control_word   = q_data.control_word;
    assign o_message_id     = q_data.message_id;
    assign o_device_address = q_data.device_address;
    assign o_payload_length = q_data.payload_length;
    assign o_crc_computed   = q_data.crc_computed;
    assign o_reader_error   = q_data.reader_error;
    assign o_frame_end      = q_data.frame_end;

endmodule

// File: bench/reader_frame_deframer_crc16_tb.sv
module reader_frame_deframer_crc16_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rfd_pkg::*;

    // Run limit in cycles. The slowest clean run is roughly 450 bytes plus the
    // long receiver hold, so this leaves a wide margin.
    localparam int CYCLE_LIMIT = 200_000;
    localparam int READY_HOLD_CYCLES = 150;

    // register map: index 0 is max_payload_len, index 1 is unused
    localparam logic [CFG_ADDR_W-1:0] MAX_LEN_ADDR    = CFG_ADDR_W'(4 * REG_MAX_LEN);
    localparam logic [CFG_ADDR_W-1:0] UNUSED_REG_ADDR = CFG_ADDR_W'(4);

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_rx_byte  = 8'h00;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [1:0]            o_kind;
    logic [7:0]            o_byte_value;
    logic [15:0]           o_payload_index;
    logic [7:0]            o_control_word;
    logic [7:0]            o_message_id;
    logic [7:0]            o_device_address;
    logic [15:0]           o_payload_length;
    logic [15:0]           o_crc_computed;
    logic                  o_reader_error;
    logic                  o_frame_end;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    reader_frame_deframer_crc16 u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_byte_value     (o_byte_value),
        .o_payload_index  (o_payload_index),
        .o_control_word   (o_control_word),
        .o_message_id     (o_message_id),
        .o_device_address (o_device_address),
        .o_payload_length (o_payload_length),
        .o_crc_computed   (o_crc_computed),
        .o_reader_error   (o_reader_error),
        .o_frame_end      (o_frame_end),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    logic [7:0] rx_stream[$];     // link bytes not yet offered
    t_result    due_results[$];   // results the deframer owes, oldest first
    t_result    want;
    int         fail_count  = 0;
    int         cycle_count = 0;
    bit         in_fire     = 1'b0;   // set by the monitor, consumed by the drivers
    bit         out_fire    = 1'b0;
    bit         drive_valid = 1'b0;   // driver's view of i_in_valid
    int         in_wait     = 0;
    int         out_wait    = 0;
    int         ready_hold  = 0;      // long receiver stall, counted down by the receiver
    bit         steady      = 1'b0;   // no idle cycles on either side while set

    // Predictor copy of the deframer: limit register plus parse state
    logic [15:0] len_limit   = MAX_LEN_RESET;
    t_phase      parse_at    = PH_HUNT;
    logic [15:0] crc_run     = '0;
    logic [15:0] payload_pos = '0;
    logic [7:0]  frame_ctrl  = '0;
    logic [7:0]  frame_id    = '0;
    logic [7:0]  frame_addr  = '0;
    logic [15:0] frame_len   = '0;
    logic [7:0]  crc_hi      = '0;

    // CRC-16, poly 0x8005, MSB first, one byte
    function automatic logic [15:0] crc8005_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        return c;
    endfunction

    // Snapshot of the current frame fields for one result
    function automatic t_result frame_result(input t_kind k, input logic [7:0] v,
                                             input logic [15:0] idx);
        t_result r;
        r.kind           = k;
        r.byte_value     = v;
        r.payload_index  = idx;
        r.control_word   = frame_ctrl;
        r.message_id     = frame_id;
        r.device_address = frame_addr;
        r.payload_length = frame_len;
        r.crc_computed   = crc_run;
        r.frame_end      = (k != KIND_DATA);
        // illegal-command flag only on status results
        r.reader_error   = r.frame_end && frame_ctrl[INIT_FLAG_BIT] &&
                           frame_id == 8'h00 && frame_len == READER_ERR_LEN;
        return r;
    endfunction

    // Advance the predicted parser by one accepted byte
    function automatic void deframe_byte(input logic [7:0] b);
        logic [15:0] idx;
        case (parse_at)
            PH_CTRL: begin
                crc_run    = crc8005_step(crc_run, b);
                frame_ctrl = b;
                parse_at   = PH_ID;
            end
            PH_ID: begin
                crc_run  = crc8005_step(crc_run, b);
                frame_id = b;
                if (frame_ctrl[ADDR_FLAG_BIT]) parse_at = PH_ADDR;
                else parse_at = PH_LENH;
            end
            PH_ADDR: begin
                crc_run    = crc8005_step(crc_run, b);
                frame_addr = b;
                parse_at   = PH_LENH;
            end
            PH_LENH: begin
                crc_run   = crc8005_step(crc_run, b);
                frame_len = {b, 8'h00};
                parse_at  = PH_LENL;
            end
            PH_LENL: begin
                crc_run        = crc8005_step(crc_run, b);
                frame_len[7:0] = b;
                payload_pos    = '0;
                if (frame_len > len_limit) begin
                    // oversize: report and go back to hunting
                    parse_at = PH_HUNT;
                    due_results.push_back(frame_result(KIND_TOO_LONG, 8'h00, 16'h0000));
                end else if (frame_len == 16'h0000) begin
                    parse_at = PH_CRCH;   // empty payload, CRC comes next
                end else begin
                    parse_at = PH_DATA;
                end
            end
            PH_DATA: begin
                idx         = payload_pos;
                crc_run     = crc8005_step(crc_run, b);
                payload_pos = payload_pos + 16'd1;
                if (payload_pos >= frame_len) parse_at = PH_CRCH;
                due_results.push_back(frame_result(KIND_DATA, b, idx));
            end
            PH_CRCH: begin
                crc_hi   = b;
                parse_at = PH_CRCL;
            end
            PH_CRCL: begin
                parse_at = PH_HUNT;
                due_results.push_back(frame_result(
                    t_kind'(({crc_hi, b} == crc_run) ? KIND_GOOD : KIND_CRC_ERR),
                    8'h00, 16'h0000));
            end
            default: begin
                // hunting: anything but the head byte is dropped
                if (b == HEAD_BYTE) begin
                    crc_run     = '0;
                    payload_pos = '0;
                    frame_addr  = '0;
                    parse_at    = PH_CTRL;
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    function automatic int pick_gap();
        return steady ? 0 : $urandom_range(0, 5);
    endfunction

    // Queue one frame on the link. CRC covers everything after the head.
    // corrupt flips one CRC bit; keep >= 0 cuts the frame to that many bytes.
    function automatic int push_frame(input logic [7:0] ctrl, input logic [7:0] id,
                                      input logic [7:0] addr, input logic [15:0] len,
                                      input logic [7:0] body[$], input bit corrupt,
                                      input int keep);
        logic [7:0]  f[$];
        logic [15:0] crc;
        f = {HEAD_BYTE, ctrl, id};
        if (ctrl[ADDR_FLAG_BIT]) f.push_back(addr);
        f.push_back(len[15:8]);
        f.push_back(len[7:0]);
        for (int i = 0; i < int'(len) && (keep < 0 || f.size() < keep); i++)
            f.push_back(i < body.size() ? body[i] : 8'($urandom));
        crc = 16'h0000;
        for (int i = 1; i < f.size(); i++) crc = crc8005_step(crc, f[i]);
        if (corrupt) crc ^= 16'(1 << $urandom_range(0, 15));
        f.push_back(crc[15:8]);
        f.push_back(crc[7:0]);
        if (keep >= 0)
            while (f.size() > keep) void'(f.pop_back());
        foreach (f[i]) rx_stream.push_back(f[i]);
        return f.size();
    endfunction

    // Mostly well-formed frames with random content. With a small limit also
    // stray bytes and cut frames, which can throw the parser off for a while;
    // a big limit would let a bogus length swallow the rest, so not there.
    task automatic random_traffic(input int count);
        int          sent;
        int          pick;
        int          hdr;
        int          keep;
        bit          breaks;
        logic [7:0]  ctrl;
        logic [7:0]  id;
        logic [7:0]  addr;
        logic [15:0] len;
        logic [7:0]  body[$];
        sent   = 0;
        breaks = (len_limit <= 16'd40);
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick >= 92 && breaks) begin
                rx_stream.push_back(8'($urandom));
            end else begin
                ctrl = 8'($urandom);
                id   = 8'($urandom);
                addr = 8'($urandom);
                len  = 16'($urandom_range(0, 10));
                if (pick < 12) begin
                    // illegal-command pattern from the reader
                    ctrl[INIT_FLAG_BIT] = 1'b1;
                    id = 8'h00;
                    if (pick < 8) len = READER_ERR_LEN;
                end
                if (pick >= 50 && pick < 55 && breaks) len = len_limit;   // right at the limit
                if (pick >= 80 && pick < 92 && len_limit != 16'hFFFF)
                    len = $urandom_range(0, 1) ? len_limit + 16'd1 :
                          16'($urandom_range(int'(len_limit) + 1, 65535));
                hdr  = ctrl[ADDR_FLAG_BIT] ? 6 : 5;
                keep = -1;
                if (len > len_limit) keep = hdr;   // block hunts right after the length
                else if (pick >= 70 && pick < 80 && breaks)
                    keep = $urandom_range(1, hdr + int'(len) + 1);
                sent += push_frame(ctrl, id, addr, len, body, pick >= 55 && pick < 70, keep);
            end
        end
    endtask

    // One APB transfer: setup cycle, then access cycle; pready is tied high
    task automatic apb_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every byte went in and every owed result came out, then wait on
    // past that, since a byte with no result may still be in the parser.
    task automatic settle();
        while (rx_stream.size() != 0 || drive_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [15:0] lim);
        logic [31:0] rd;
        settle();
        // upper pwdata bits are junk; only the low 16 belong to the register
        apb_access(1'b1, MAX_LEN_ADDR, {16'($urandom), lim}, rd);
        len_limit = lim;
        apb_access(1'b0, MAX_LEN_ADDR, 32'h0, rd);
        if (rd[15:0] !== lim) begin
            $error("max_payload_len readback: expected %0h, got %0h", lim, rd[15:0]);
            fail_count++;
        end
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Byte driver: pops the next link byte, holds it until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                in_fire     = 1'b0;
                drive_valid = 1'b0;
                in_wait     = pick_gap();
            end
            if (!drive_valid) begin
                if (in_wait > 0) begin
                    in_wait--;
                end else if (rx_stream.size() != 0) begin
                    i_rx_byte   <= rx_stream.pop_front();
                    drive_valid = 1'b1;
                end
            end
            i_in_valid <= drive_valid;
        end
    end

    // Result receiver: random back-pressure per item, plus one long hold
    always @(negedge i_clk) begin
        if (out_fire) begin
            out_fire = 1'b0;
            out_wait = pick_gap();
        end
        if (ready_hold > 0) begin
            ready_hold--;
            i_out_ready <= 1'b0;
        end else if (out_wait > 0) begin
            out_wait--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks taken results, feeds taken bytes to the predictor.
    // A result is registered in the queue before it is offered, so the order here is safe.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                out_fire = 1'b1;
                if (due_results.size() == 0) begin
                    $error("result with nothing due: kind %0d, byte %0h", o_kind, o_byte_value);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("byte_value", want.byte_value, o_byte_value);
                    check_field("payload_index", want.payload_index, o_payload_index);
                    check_field("control_word", want.control_word, o_control_word);
                    check_field("message_id", want.message_id, o_message_id);
                    check_field("device_address", want.device_address, o_device_address);
                    check_field("payload_length", want.payload_length, o_payload_length);
                    check_field("crc_computed", want.crc_computed, o_crc_computed);
                    check_field("reader_error", want.reader_error, o_reader_error);
                    check_field("frame_end", want.frame_end, o_frame_end);
                end
            end
            if (i_in_valid && o_in_ready) begin
                in_fire = 1'b1;
                deframe_byte(i_rx_byte);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] rd;
        logic [7:0]  body[$];

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, at the reset limit of 1024:
        // stray byte while hunting, ignored
        rx_stream.push_back(8'h55);
        // illegal-command frame, good CRC, head byte and byte extremes in the payload
        body = {8'h00, HEAD_BYTE, 8'hFF, 8'h01, 8'h80, 8'h7F};
        void'(push_frame(8'h10, 8'h00, 8'h00, READER_ERR_LEN, body, 1'b0, -1));
        // address present, empty payload, bad CRC
        body = {};
        void'(push_frame(8'hFF, 8'hFF, 8'hFF, 16'h0000, body, 1'b1, -1));
        // largest length, over the limit
        void'(push_frame(8'h00, 8'h00, 8'h00, 16'hFFFF, body, 1'b0, 5));
        settle();

        // write to the unused register must leave the limit alone
        apb_access(1'b1, UNUSED_REG_ADDR, 32'h0000_0003, rd);
        void'(push_frame(8'h21, 8'h42, 8'h99, 16'd20, body, 1'b0, -1));

        // small limit; receiver stalls long so the input side backs up
        set_limit(16'd16);
        random_traffic(24);
        @(posedge i_clk);
        ready_hold = READY_HOLD_CYCLES;

        // zero limit: only empty payloads pass; back to back, no idling
        set_limit(16'd0);
        steady = 1'b1;
        random_traffic(16);

        // largest limit, with one long payload to walk the index high bits
        set_limit(16'hFFFF);
        steady = 1'b0;
        void'(push_frame(8'h20, 8'h5A, 8'hC3, 16'($urandom_range(257, 264)), body, 1'b0, -1));
        random_traffic(16);

        // limit equal to the illegal-command length
        set_limit(READER_ERR_LEN);
        random_traffic(16);

        set_limit(16'($urandom_range(1, 40)));
        steady = 1'b1;
        random_traffic(8);
        steady = 1'b0;
        random_traffic(8);

        settle();
        repeat (8) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d results never arrived", due_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: reader_frame_deframer_crc16.f
design/rfd_pkg.sv
design/rfd_cfg.sv
design/rfd_parse.sv
design/rfd_outq.sv
design/reader_frame_deframer_crc16.sv
bench/reader_frame_deframer_crc16_tb.sv
